### design/llaa_pkg.sv
`timescale 1ns / 1ps
package llaa_pkg;

   localparam logic [24:0] ONE_Q24 = 25'h1000000;
   localparam int DIV_W = 88;
   localparam int DSR_W = 33;

   typedef enum logic [2:0] {
      CMD_EVAL  = 3'd0,
      CMD_ACCUM = 3'd1,
      CMD_STEP  = 3'd2,
      CMD_LOAD  = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_GRID_LOW    = 3'd0,
      CSR_INDEX_SCALE = 3'd1,
      CSR_LEARN_RATE  = 3'd2,
      CSR_BETA_ONE    = 3'd3,
      CSR_BETA_TWO    = 3'd4,
      CSR_EPSILON     = 3'd5
   } csr_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE,
      ST_LMUL, ST_LOC, ST_RDA, ST_RDB, ST_MUL, ST_FIN, ST_WRLO,
      ST_RDX, ST_RDXD,
      ST_POW, ST_ARD, ST_AM1, ST_AM2, ST_AM3,
      ST_DIVM, ST_WAITM, ST_DIVV, ST_WAITV, ST_SQRT,
      ST_SMUL, ST_DIVS, ST_WAITS, ST_AWR,
      ST_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(x);
      end
      return r;
   endfunction

endpackage

### design/learned_lut_activation_adam_core.sv
`timescale 1ns / 1ps
// Trainable piecewise-linear activation with an Adam optimizer.
// Request beat (req_*): command, sample, delta, entry index and entry value;
// taken when req_valid is high and req_stall low. Every request returns
// exactly one response beat on rsp_* (rsp_valid, held while rsp_stall).
// Registers are written on the csr port (csr_ready is always high). The user
// must write them only while no request is in flight; the block itself does
// not enforce this. Each request is finished before the next one is taken.
// The optimizer step walks every entry through one read-modify-write of the
// four state memories, waiting per entry on up to three divisions in the
// shared bit-serial divider and on the iterative square root.
// The response sits in an output register: the next request is taken while
// an earlier response is still stalled, and a finished item waits in its
// last state until the output register is free.
// After reset the block sweeps all memories to zero, one entry a cycle over all
// TABLE_ENTRIES entries, and holds req_stall high during the sweep.
module learned_lut_activation_adam_core
   import llaa_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_sample,
   input  logic signed [31:0] req_delta,
   input  logic [5:0]         req_entry_index,
   input  logic signed [31:0] req_entry_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
   localparam logic signed [16:0] IDX_MAX = 17'(TABLE_ENTRIES - 2);

   state_type state_ff, state_in;

   logic [IW-1:0]       addr_ff, addr_in;
   cmd_type             cmd_ff, cmd_in;
   logic signed [31:0]  sample_ff, sample_in;
   logic signed [31:0]  delta_ff, delta_in;
   logic [5:0]          ei_ff, ei_in;
   logic signed [31:0]  res_ff, res_in;
   logic signed [64:0]  lprod_ff, lprod_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic signed [41:0]  frac_ff, frac_in;
   logic signed [31:0]  a0_ff, a0_in;
   logic signed [31:0]  a1_ff, a1_in;
   logic signed [50:0]  ph_ff, ph_in;
   logic signed [57:0]  pl_ff, pl_in;
   logic signed [31:0]  lo_ff, lo_in;
   logic [24:0]         pow1_ff, pow1_in;
   logic [24:0]         pow2_ff, pow2_in;
   logic signed [31:0]  val_ff, val_in;
   logic signed [57:0]  pm1_ff, pm1_in;
   logic signed [57:0]  pm2_ff, pm2_in;
   logic [63:0]         gsq_ff, gsq_in;
   logic [64:0]         vh_ff, vh_in;
   logic [48:0]         vl_ff, vl_in;
   logic signed [31:0]  mnew_ff, mnew_in;
   logic [64:0]         gh_ff, gh_in;
   logic [48:0]         gl_ff, gl_in;
   logic [63:0]         vpart_ff, vpart_in;
   logic [63:0]         vnew_ff, vnew_in;
   logic signed [31:0]  mh_ff, mh_in;
   logic [63:0]         sq_x_ff, sq_x_in;
   logic [33:0]         sq_rem_ff, sq_rem_in;
   logic [31:0]         sq_root_ff, sq_root_in;
   logic [4:0]          sq_cnt_ff, sq_cnt_in;
   logic [32:0]         denom_ff, denom_in;
   logic [56:0]         sprod_ff, sprod_in;
   logic signed [57:0]  step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_value_ff, rsp_value_in;

   logic signed [31:0]  grid_low_ff, grid_low_in;
   logic [30:0]         index_scale_ff, index_scale_in;
   logic [24:0]         learn_rate_ff, learn_rate_in;
   logic [24:0]         beta_one_ff, beta_one_in;
   logic [24:0]         beta_two_ff, beta_two_in;
   logic [24:0]         epsilon_ff, epsilon_in;

   logic                accept;
   logic [IW-1:0]       rd_addr;
   logic                tv_we, gr_we, mo_we, sm_we;
   logic [IW-1:0]       tv_wa, gr_wa, mo_wa, sm_wa;
   logic [31:0]         tv_wd, gr_wd, mo_wd;
   logic [63:0]         sm_wd;
   logic [31:0]         tv_rd, gr_rd, mo_rd;
   logic [63:0]         sm_rd;
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_dividend, div_quot;
   logic [DSR_W-1:0]    div_divisor;

   logic [24:0]         b1c, b2c, ob1, ob2, c1, c2;
   logic [31:0]         mabs, mhabs;
   logic signed [63:0]  fsum, lo_sum, hi_sum;
   logic signed [32:0]  opnd;
   logic signed [40:0]  pos;
   logic signed [16:0]  ipart;
   logic [IW-1:0]       idx_c;
   logic signed [58:0]  msum;
   logic signed [63:0]  gsq_s, qs;
   logic [49:0]         p1, p2;
   logic [35:0]         rem_sh, trial;
   logic                ei_ok, req_ei_ok;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   assign b1c = (beta_one_ff > ONE_Q24) ? ONE_Q24 : beta_one_ff;
   assign b2c = (beta_two_ff > ONE_Q24) ? ONE_Q24 : beta_two_ff;
   assign ob1 = ONE_Q24 - b1c;
   assign ob2 = ONE_Q24 - b2c;
   assign c1  = (pow1_ff == ONE_Q24) ? ONE_Q24 : ONE_Q24 - pow1_ff;
   assign c2  = (pow2_ff == ONE_Q24) ? ONE_Q24 : ONE_Q24 - pow2_ff;
   assign mabs  = mnew_ff[31] ? (32'd0 - $unsigned(mnew_ff)) : $unsigned(mnew_ff);
   assign mhabs = mh_ff[31] ? (32'd0 - $unsigned(mh_ff)) : $unsigned(mh_ff);
   assign ei_ok     = {26'd0, ei_ff} < 32'(TABLE_ENTRIES);
   assign req_ei_ok = {26'd0, req_entry_index} < 32'(TABLE_ENTRIES);

   llaa_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_values (
      .clock(clock), .wr_en(tv_we), .wr_addr(tv_wa), .wr_data(tv_wd),
      .rd_addr(rd_addr), .rd_data(tv_rd)
   );
   llaa_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_grads (
      .clock(clock), .wr_en(gr_we), .wr_addr(gr_wa), .wr_data(gr_wd),
      .rd_addr(rd_addr), .rd_data(gr_rd)
   );
   llaa_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_first (
      .clock(clock), .wr_en(mo_we), .wr_addr(mo_wa), .wr_data(mo_wd),
      .rd_addr(rd_addr), .rd_data(mo_rd)
   );
   llaa_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_second (
      .clock(clock), .wr_en(sm_we), .wr_addr(sm_wa), .wr_data(sm_wd),
      .rd_addr(rd_addr), .rd_data(sm_rd)
   );

   llaa_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_EVAL, CMD_ACCUM: state_in = ST_LMUL;
                  CMD_STEP:            state_in = ST_POW;
                  CMD_READ:            state_in = ST_RDX;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_LMUL:  state_in = ST_LOC;
         ST_LOC:   state_in = ST_RDA;
         ST_RDA:   state_in = ST_RDB;
         ST_RDB:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_FIN;
         ST_FIN:   state_in = (cmd_ff == CMD_ACCUM) ? ST_WRLO : ST_DONE;
         ST_WRLO:  state_in = ST_DONE;
         ST_RDX:   state_in = ST_RDXD;
         ST_RDXD:  state_in = ST_DONE;
         ST_POW:   state_in = ST_ARD;
         ST_ARD:   state_in = ST_AM1;
         ST_AM1:   state_in = ST_AM2;
         ST_AM2:   state_in = ST_AM3;
         ST_AM3:   state_in = ST_DIVM;
         ST_DIVM:  state_in = ST_WAITM;
         ST_WAITM: begin
            if (div_done) state_in = ST_DIVV;
         end
         ST_DIVV:  state_in = ST_WAITV;
         ST_WAITV: begin
            if (div_done) state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_cnt_ff == 5'd31) state_in = ST_SMUL;
         end
         ST_SMUL:  state_in = ST_DIVS;
         ST_DIVS:  state_in = (denom_ff == '0) ? ST_AWR : ST_WAITS;
         ST_WAITS: begin
            if (div_done) state_in = ST_AWR;
         end
         ST_AWR:   state_in = (addr_ff == LAST) ? ST_DONE : ST_ARD;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory, divider and handshake control
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      rd_addr      = addr_ff;
      tv_we = 1'b0; tv_wa = addr_ff; tv_wd = '0;
      gr_we = 1'b0; gr_wa = addr_ff; gr_wd = '0;
      mo_we = 1'b0; mo_wa = addr_ff; mo_wd = '0;
      sm_we = 1'b0; sm_wa = addr_ff; sm_wd = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            tv_we = 1'b1;
            gr_we = 1'b1;
            mo_we = 1'b1;
            sm_we = 1'b1;
         end
         ST_IDLE: begin
            if (accept && cmd_type'(req_cmd) == CMD_LOAD && req_ei_ok) begin
               tv_we = 1'b1;
               tv_wa = IW'(req_entry_index);
               tv_wd = req_entry_value;
            end
         end
         ST_RDA:  rd_addr = idx_ff;
         ST_RDB:  rd_addr = IW'(idx_ff + 1'b1);
         ST_RDX:  rd_addr = IW'(ei_ff);
         ST_FIN: begin
            if (cmd_ff == CMD_ACCUM) begin
               gr_we = 1'b1;
               gr_wa = IW'(idx_ff + 1'b1);
               gr_wd = sat32(hi_sum);
            end
         end
         ST_WRLO: begin
            gr_we = 1'b1;
            gr_wa = idx_ff;
            gr_wd = lo_ff;
         end
         ST_DIVM: begin
            gr_we = 1'b1;
            mo_we = 1'b1;
            mo_wd = mnew_ff;
            sm_we = 1'b1;
            sm_wd = vnew_ff;
            div_start    = 1'b1;
            div_dividend = DIV_W'({mabs, 24'd0});
            div_divisor  = DSR_W'(c1);
         end
         ST_DIVV: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'({vnew_ff, 24'd0});
            div_divisor  = DSR_W'(c2);
         end
         ST_DIVS: begin
            div_start    = (denom_ff != '0);
            div_dividend = DIV_W'(sprod_ff);
            div_divisor  = denom_ff;
         end
         ST_AWR: begin
            tv_we = 1'b1;
            tv_wd = sat32(64'(val_ff) - 64'(step_ff));
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      addr_in = addr_ff;  cmd_in = cmd_ff;  sample_in = sample_ff;
      delta_in = delta_ff; ei_in = ei_ff;   res_in = res_ff;
      lprod_in = lprod_ff; idx_in = idx_ff; frac_in = frac_ff;
      a0_in = a0_ff; a1_in = a1_ff; ph_in = ph_ff; pl_in = pl_ff; lo_in = lo_ff;
      pow1_in = pow1_ff; pow2_in = pow2_ff; val_in = val_ff;
      pm1_in = pm1_ff; pm2_in = pm2_ff; gsq_in = gsq_ff; vh_in = vh_ff; vl_in = vl_ff;
      mnew_in = mnew_ff; gh_in = gh_ff; gl_in = gl_ff; vpart_in = vpart_ff;
      vnew_in = vnew_ff; mh_in = mh_ff;
      sq_x_in = sq_x_ff; sq_rem_in = sq_rem_ff; sq_root_in = sq_root_ff;
      sq_cnt_in = sq_cnt_ff;
      denom_in = denom_ff; sprod_in = sprod_ff; step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;

      pos    = $signed(lprod_ff[64:24]);
      ipart  = $signed(lprod_ff[64:48]);
      if (ipart < 17'sd0) begin
         idx_c = '0;
      end else if (ipart > IDX_MAX) begin
         idx_c = IW'(IDX_MAX);
      end else begin
         idx_c = IW'(ipart);
      end
      opnd   = (cmd_ff == CMD_EVAL) ? (33'($signed(tv_rd)) - 33'(a0_ff)) : 33'(delta_ff);
      fsum   = 64'(ph_ff) + 64'($signed(pl_ff[57:24]));
      hi_sum = 64'(a1_ff) + fsum;
      lo_sum = 64'(a0_ff) + 64'(delta_ff) - fsum - (|pl_ff[23:0] ? 64'sd1 : 64'sd0);
      msum   = 59'(pm1_ff) + 59'(pm2_ff);
      gsq_s  = $signed(gr_rd) * $signed(gr_rd);
      p1     = pow1_ff * b1c;
      p2     = pow2_ff * b2c;
      qs     = $signed({1'b0, div_quot[62:0]});
      rem_sh = {sq_rem_ff, sq_x_ff[63:62]};
      trial  = {2'b00, sq_root_ff, 2'b01};

      unique case (state_ff)
         ST_CLEAR: begin
            addr_in = (addr_ff == LAST) ? '0 : IW'(addr_ff + 1'b1);
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = cmd_type'(req_cmd);
               sample_in = req_sample;
               delta_in  = req_delta;
               ei_in     = req_entry_index;
               res_in    = '0;
            end
         end
         ST_LMUL: begin
            lprod_in = (33'(sample_ff) - 33'(grid_low_ff)) * $signed({1'b0, index_scale_ff});
         end
         ST_LOC: begin
            idx_in  = idx_c;
            frac_in = 42'(pos) - $signed(42'({idx_c, 24'd0}));
         end
         ST_RDB: begin
            a0_in = (cmd_ff == CMD_EVAL) ? $signed(tv_rd) : $signed(gr_rd);
         end
         ST_MUL: begin
            a1_in = $signed(gr_rd);
            ph_in = opnd * $signed(frac_ff[41:24]);
            pl_in = opnd * $signed({1'b0, frac_ff[23:0]});
         end
         ST_FIN: begin
            if (cmd_ff == CMD_EVAL) res_in = sat32(64'(a0_ff) + fsum);
            lo_in = sat32(lo_sum);
         end
         ST_RDXD: begin
            res_in = ei_ok ? $signed(tv_rd) : 32'sd0;
         end
         ST_POW: begin
            pow1_in = p1[48:24];
            pow2_in = p2[48:24];
            addr_in = '0;
         end
         ST_AM1: begin
            val_in = $signed(tv_rd);
            pm1_in = $signed({1'b0, b1c}) * $signed(mo_rd);
            pm2_in = $signed({1'b0, ob1}) * $signed(gr_rd);
            gsq_in = $unsigned(gsq_s);
            vh_in  = sm_rd[63:24] * b2c;
            vl_in  = sm_rd[23:0] * b2c;
         end
         ST_AM2: begin
            mnew_in  = sat32(64'($signed(msum[58:24])));
            gh_in    = gsq_ff[63:24] * ob2;
            gl_in    = gsq_ff[23:0] * ob2;
            vpart_in = 64'(vh_ff + 65'(vl_ff >> 24));
         end
         ST_AM3: begin
            vnew_in = 64'(65'(vpart_ff) + gh_ff + 65'(gl_ff >> 24));
         end
         ST_WAITM: begin
            if (div_done) mh_in = sat32(mnew_ff[31] ? -qs : qs);
         end
         ST_WAITV: begin
            if (div_done) begin
               sq_x_in    = (|div_quot[DIV_W-1:64]) ? '1 : div_quot[63:0];
               sq_rem_in  = '0;
               sq_root_in = '0;
               sq_cnt_in  = '0;
            end
         end
         ST_SQRT: begin
            if (rem_sh >= trial) begin
               sq_rem_in  = 34'(rem_sh - trial);
               sq_root_in = {sq_root_ff[30:0], 1'b1};
            end else begin
               sq_rem_in  = 34'(rem_sh);
               sq_root_in = {sq_root_ff[30:0], 1'b0};
            end
            sq_x_in   = {sq_x_ff[61:0], 2'b00};
            sq_cnt_in = sq_cnt_ff + 1'b1;
         end
         ST_SMUL: begin
            denom_in = 33'(sq_root_ff) + 33'(epsilon_ff);
            sprod_in = learn_rate_ff * mhabs;
         end
         ST_DIVS: begin
            if (denom_ff == '0) step_in = '0;
         end
         ST_WAITS: begin
            if (div_done) begin
               step_in = mh_ff[31] ? -$signed({1'b0, div_quot[56:0]})
                                   : $signed({1'b0, div_quot[56:0]});
            end
         end
         ST_AWR: begin
            addr_in = (addr_ff == LAST) ? '0 : IW'(addr_ff + 1'b1);
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // register writes
   always_comb begin
      grid_low_in    = grid_low_ff;
      index_scale_in = index_scale_ff;
      learn_rate_in  = learn_rate_ff;
      beta_one_in    = beta_one_ff;
      beta_two_in    = beta_two_ff;
      epsilon_in     = epsilon_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_LOW:    grid_low_in    = $signed(csr_data);
            CSR_INDEX_SCALE: index_scale_in = csr_data[30:0];
            CSR_LEARN_RATE:  learn_rate_in  = csr_data[24:0];
            CSR_BETA_ONE:    beta_one_in    = csr_data[24:0];
            CSR_BETA_TWO:    beta_two_in    = csr_data[24:0];
            CSR_EPSILON:     epsilon_in     = csr_data[24:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         addr_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         pow1_ff        <= ONE_Q24;
         pow2_ff        <= ONE_Q24;
         sq_cnt_ff      <= '0;
         grid_low_ff    <= -32'sd83886080;
         index_scale_ff <= 31'd105696461;
         learn_rate_ff  <= 25'd167772;
         beta_one_ff    <= 25'd15099494;
         beta_two_ff    <= 25'd16760438;
         epsilon_ff     <= 25'd1;
      end else begin
         state_ff       <= state_in;
         addr_ff        <= addr_in;
         rsp_valid_ff   <= rsp_valid_in;
         pow1_ff        <= pow1_in;
         pow2_ff        <= pow2_in;
         sq_cnt_ff      <= sq_cnt_in;
         grid_low_ff    <= grid_low_in;
         index_scale_ff <= index_scale_in;
         learn_rate_ff  <= learn_rate_in;
         beta_one_ff    <= beta_one_in;
         beta_two_ff    <= beta_two_in;
         epsilon_ff     <= epsilon_in;
      end
      cmd_ff       <= cmd_in;
      sample_ff    <= sample_in;
      delta_ff     <= delta_in;
      ei_ff        <= ei_in;
      res_ff       <= res_in;
      lprod_ff     <= lprod_in;
      idx_ff       <= idx_in;
      frac_ff      <= frac_in;
      a0_ff        <= a0_in;
      a1_ff        <= a1_in;
      ph_ff        <= ph_in;
      pl_ff        <= pl_in;
      lo_ff        <= lo_in;
      val_ff       <= val_in;
      pm1_ff       <= pm1_in;
      pm2_ff       <= pm2_in;
      gsq_ff       <= gsq_in;
      vh_ff        <= vh_in;
      vl_ff        <= vl_in;
      mnew_ff      <= mnew_in;
      gh_ff        <= gh_in;
      gl_ff        <= gl_in;
      vpart_ff     <= vpart_in;
      vnew_ff      <= vnew_in;
      mh_ff        <= mh_in;
      sq_x_ff      <= sq_x_in;
      sq_rem_ff    <= sq_rem_in;
      sq_root_ff   <= sq_root_in;
      denom_ff     <= denom_in;
      sprod_ff     <= sprod_in;
      step_ff      <= step_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

### design/llaa_ram.sv
`timescale 1ns / 1ps
module llaa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/llaa_div.sv
`timescale 1ns / 1ps
module llaa_div
   import llaa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CW = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      rem_sh  = {rem_ff, dvd_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIV_W);
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? DSR_W'(rem_sh - {1'b0, dsr_ff}) : DSR_W'(rem_sh);
         dvd_in = {dvd_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import llaa_pkg::*;

   localparam int ENTRIES = 64;
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam longint Q24_ONE = 64'sd16777216;

   typedef struct {
      logic [2:0]         cmd;
      logic signed [31:0] sample;
      logic signed [31:0] delta;
      logic [5:0]         index;
      logic signed [31:0] value;
   } lut_req_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_cmd = '0;
   logic signed [31:0] req_sample = '0;
   logic signed [31:0] req_delta = '0;
   logic [5:0]         req_entry_index = '0;
   logic signed [31:0] req_entry_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   learned_lut_activation_adam_core #(.TABLE_ENTRIES(ENTRIES)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_sample(req_sample), .req_delta(req_delta),
      .req_entry_index(req_entry_index), .req_entry_value(req_entry_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow of the block state
   int signed   lut_values [ENTRIES];
   int signed   lut_grads [ENTRIES];
   int signed   lut_moment1 [ENTRIES];
   logic [63:0] lut_moment2 [ENTRIES];
   logic [24:0] decay_pow1 = ONE_Q24;
   logic [24:0] decay_pow2 = ONE_Q24;

   logic signed [31:0] grid_low_q = -32'sd83886080;
   logic [30:0]        scale_q = 31'd105696461;
   logic [24:0]        lr_q = 25'd167772;
   logic [24:0]        beta1_q = 25'd15099494;
   logic [24:0]        beta2_q = 25'd16760438;
   logic [24:0]        eps_q = 25'd1;

   int signed expected_results [$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int mismatches = 0;
   int checked = 0;
   int sent = 0;
   int steps_sent = 0;
   int settings_used = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int signed clip32(input longint x);
      if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return int'(x);
   endfunction

   function automatic longint mul_floor24(input longint a, input longint b);
      logic signed [127:0] wa, wb, p;
      wa = a;
      wb = b;
      p = wa * wb;
      return longint'(p >>> 24);
   endfunction

   function automatic void find_segment(input logic signed [31:0] x, output int seg,
                                        output longint frac);
      logic signed [95:0] dx, gl, sc, prod;
      longint pos, i;
      dx = x;
      gl = grid_low_q;
      sc = {65'b0, scale_q};
      prod = (dx - gl) * sc;
      pos = longint'(prod >>> 24);
      i = pos >>> 24;
      if (i < 0) i = 0;
      if (i > ENTRIES - 2) i = ENTRIES - 2;
      seg = int'(i);
      frac = pos - (i <<< 24);
   endfunction

   function automatic logic [63:0] decay64(input logic [63:0] v, input logic [63:0] b);
      return (v >> 24) * b + (((v & 64'hFFFFFF) * b) >> 24);
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] x);
      logic [63:0] r, t;
      r = 0;
      for (int bit_pos = 31; bit_pos >= 0; bit_pos--) begin
         t = r | (64'd1 << bit_pos);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   task automatic adam_update();
      logic [63:0] b1, b2, gsq, v, hi, rem, q, denom, c2u;
      longint c1, c2, g, m, mh, step;
      b1 = (beta1_q > ONE_Q24) ? 64'(ONE_Q24) : 64'(beta1_q);
      b2 = (beta2_q > ONE_Q24) ? 64'(ONE_Q24) : 64'(beta2_q);
      decay_pow1 = 25'((64'(decay_pow1) * b1) >> 24);
      decay_pow2 = 25'((64'(decay_pow2) * b2) >> 24);
      c1 = Q24_ONE - longint'(decay_pow1);
      c2 = Q24_ONE - longint'(decay_pow2);
      if (c1 <= 0) c1 = Q24_ONE;
      if (c2 <= 0) c2 = Q24_ONE;
      c2u = 64'(c2);
      for (int e = 0; e < ENTRIES; e++) begin
         g = lut_grads[e];
         gsq = 64'(g * g);
         m = (longint'(b1) * lut_moment1[e] + (Q24_ONE - longint'(b1)) * g) >>> 24;
         v = decay64(lut_moment2[e], b2) + decay64(gsq, 64'(ONE_Q24) - b2);
         lut_moment1[e] = clip32(m);
         lut_moment2[e] = v;
         mh = clip32((longint'(lut_moment1[e]) * Q24_ONE) / c1);
         hi = v / c2u;
         rem = v % c2u;
         if (hi >= (64'd1 << 40)) q = '1;
         else q = (hi << 24) + ((rem << 24) / c2u);
         denom = root_floor(q) + 64'(eps_q);
         step = (denom == 0) ? 0 : (longint'(lr_q) * mh) / longint'(denom);
         lut_values[e] = clip32(longint'(lut_values[e]) - step);
         lut_grads[e] = 0;
      end
   endtask

   task automatic predict_response(input lut_req_type it, output int signed res);
      int seg;
      longint frac, v0, v1;
      res = 0;
      case (it.cmd)
         CMD_EVAL: begin
            find_segment(it.sample, seg, frac);
            v0 = lut_values[seg];
            v1 = lut_values[seg + 1];
            res = clip32(v0 + mul_floor24(v1 - v0, frac));
         end
         CMD_ACCUM: begin
            find_segment(it.sample, seg, frac);
            lut_grads[seg] = clip32(longint'(lut_grads[seg])
                                    + mul_floor24(it.delta, Q24_ONE - frac));
            lut_grads[seg + 1] = clip32(longint'(lut_grads[seg + 1])
                                        + mul_floor24(it.delta, frac));
         end
         CMD_STEP: adam_update();
         CMD_LOAD: lut_values[it.index] = it.value;
         CMD_READ: res = lut_values[it.index];
         default: res = 0;
      endcase
   endtask

   task automatic send_beat(input lut_req_type it);
      int gap;
      int signed res;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= it.cmd;
      req_sample <= it.sample;
      req_delta <= it.delta;
      req_entry_index <= it.index;
      req_entry_value <= it.value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_response(it, res);
      expected_results.push_back(res);
      sent++;
      if (it.cmd == CMD_STEP) steps_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (expected_results.size() == 0);
      @(posedge clock);
   endtask

   task automatic csr_write(input csr_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_GRID_LOW: grid_low_q = data;
         CSR_INDEX_SCALE: scale_q = data[30:0];
         CSR_LEARN_RATE: lr_q = data[24:0];
         CSR_BETA_ONE: beta1_q = data[24:0];
         CSR_BETA_TWO: beta2_q = data[24:0];
         CSR_EPSILON: eps_q = data[24:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [31:0] gl, input logic [31:0] sc,
                                 input logic [31:0] lr, input logic [31:0] b1,
                                 input logic [31:0] b2, input logic [31:0] ep);
      drain();
      csr_write(CSR_GRID_LOW, gl);
      csr_write(CSR_INDEX_SCALE, sc);
      csr_write(CSR_LEARN_RATE, lr);
      csr_write(CSR_BETA_ONE, b1);
      csr_write(CSR_BETA_TWO, b2);
      csr_write(CSR_EPSILON, ep);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic lut_req_type make_req(input logic [2:0] c, input logic signed [31:0] s,
                                            input logic signed [31:0] d, input logic [5:0] ix,
                                            input logic signed [31:0] v);
      lut_req_type it;
      it.cmd = c;
      it.sample = s;
      it.delta = d;
      it.index = ix;
      it.value = v;
      return it;
   endfunction

   function automatic lut_req_type random_req();
      lut_req_type it;
      int r;
      logic signed [31:0] span;
      it = make_req(CMD_EVAL, $urandom, $urandom, 6'($urandom_range(63)), $urandom);
      span = 32'((64'd1 << 48) / (64'(scale_q) + 1));
      r = $urandom_range(99);
      if ($urandom_range(3) != 0) it.sample = grid_low_q + 32'($urandom_range(span * 66));
      it.delta = $signed(it.delta) >>> $urandom_range(0, 14);
      if ($urandom_range(3) != 0) it.value = $signed(it.value) >>> $urandom_range(1, 8);
      if (r < 35) it.cmd = CMD_EVAL;
      else if (r < 65) it.cmd = CMD_ACCUM;
      else if (r < 80) it.cmd = CMD_LOAD;
      else if (r < 93) it.cmd = CMD_READ;
      else if (r == 93) it.cmd = CMD_STEP;
      else if (r < 96) it.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      else it.cmd = 3'($urandom_range(7));
      return it;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d", rsp_result_value);
         end else begin
            int signed want;
            want = expected_results.pop_front();
            checked++;
            if (rsp_result_value !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result_value mismatch: expected %0d actual %0d",
                           want, rsp_result_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic test_directed();
      send_beat(make_req(CMD_LOAD, 0, 0, 6'd0, 32'sh7FFFFFFF));
      send_beat(make_req(CMD_LOAD, 0, 0, 6'd1, 32'sh80000000));
      send_beat(make_req(CMD_LOAD, 0, 0, 6'd62, -32'sd50331648));
      send_beat(make_req(CMD_LOAD, 0, 0, 6'd63, 32'sd83886080));
      send_beat(make_req(CMD_READ, 0, 0, 6'd0, 0));
      send_beat(make_req(CMD_READ, 0, 0, 6'd63, 0));
      send_beat(make_req(CMD_EVAL, grid_low_q, 0, 0, 0));
      send_beat(make_req(CMD_EVAL, 32'sh80000000, 0, 0, 0));
      send_beat(make_req(CMD_EVAL, 32'sh7FFFFFFF, 0, 0, 0));
      send_beat(make_req(CMD_EVAL, 32'sd8388608, 0, 0, 0));
      send_beat(make_req(CMD_ACCUM, 32'sh80000000, 32'sh7FFFFFFF, 0, 0));
      send_beat(make_req(CMD_ACCUM, 32'sh80000000, 32'sh7FFFFFFF, 0, 0));
      send_beat(make_req(CMD_ACCUM, 32'sh7FFFFFFF, 32'sh80000000, 0, 0));
      send_beat(make_req(CMD_ACCUM, 32'sd1000000, -32'sd16777216, 0, 0));
      send_beat(make_req(CMD_STEP, 0, 0, 0, 0));
      send_beat(make_req(CMD_READ, 0, 0, 6'd0, 0));
      send_beat(make_req(CMD_READ, 0, 0, 6'd1, 0));
      send_beat(make_req(CMD_READ, 0, 0, 6'd62, 0));
      send_beat(make_req(CMD_SPARE_LO, $urandom, $urandom, 6'd63, $urandom));
      send_beat(make_req(CMD_SPARE_HI, $urandom, $urandom, 6'd5, $urandom));
      send_beat(make_req(CMD_EVAL, 32'sd0, 0, 0, 0));
   endtask

   task automatic test_extreme_settings();
      apply_settings(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1000000, 32'h1000000,
                     32'h1000000, 32'h0);
      send_beat(make_req(CMD_EVAL, 32'sh80000000, 0, 0, 0));
      send_beat(make_req(CMD_ACCUM, 32'sh80000000, 32'sd16777216, 0, 0));
      send_beat(make_req(CMD_ACCUM, 32'sh7FFFFFFF, -32'sd16777216, 0, 0));
      send_beat(make_req(CMD_STEP, 0, 0, 0, 0));
      send_beat(make_req(CMD_READ, 0, 0, 6'd63, 0));
      apply_settings(32'h80000000, 32'h0, 32'h1000000, 32'h0, 32'h0, 32'h0);
      send_beat(make_req(CMD_EVAL, 32'sh7FFFFFFF, 0, 0, 0));
      send_beat(make_req(CMD_ACCUM, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0));
      send_beat(make_req(CMD_STEP, 0, 0, 0, 0));
      send_beat(make_req(CMD_STEP, 0, 0, 0, 0));
      send_beat(make_req(CMD_READ, 0, 0, 6'd0, 0));
      apply_settings(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h1FFFFFF, 32'h1FFFFFF,
                     32'h1000000);
      send_beat(make_req(CMD_ACCUM, 32'sd0, 32'sd33554432, 0, 0));
      send_beat(make_req(CMD_STEP, 0, 0, 0, 0));
      send_beat(make_req(CMD_EVAL, 32'sh80000000, 0, 0, 0));
   endtask

   task automatic test_backpressure();
      drain();
      hold_left = 600;
      repeat (40) send_beat(random_req());
      drain();
      repeat (20) send_beat(random_req());
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 65 : (ph == 3) ? 24 : 0;
         stall_pct = (ph == 2) ? 65 : (ph == 3) ? 24 : 0;
         if (ph == 0)
            apply_settings(-32'sd83886080, 32'd105696461, 32'd167772, 32'd15099494,
                           32'd16760438, 32'd1);
         else
            apply_settings(-($urandom_range(1, 8) << 24), $urandom_range(1 << 22, 1 << 28),
                           $urandom_range(0, 1 << 20), $urandom_range(14000000, 1 << 24),
                           $urandom_range(16000000, 1 << 24), $urandom_range(0, 1000));
         for (int n = 0; n < 380; n++) begin
            if ($urandom_range(199) == 0) drain();
            send_beat(random_req());
         end
      end
   endtask

   initial begin
      for (int e = 0; e < ENTRIES; e++) begin
         lut_values[e] = 0;
         lut_grads[e] = 0;
         lut_moment1[e] = 0;
         lut_moment2[e] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_extreme_settings();
      test_backpressure();
      test_random();
      drain();
      repeat (50) @(posedge clock);
      $display("Sent %0d beats (%0d optimizer steps) under %0d register settings,",
               sent, steps_sent, settings_used);
      $display("checked %0d results with idle, stall and hold-off phases", checked);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
